// ===== hdl/pcrrip_pkg.sv =====
// ----------------------------------------------------------------------------
// pcrrip_pkg
// Shared constants and controller/datapath interface types for the
// PC-classified RRIP replacement block.
// ----------------------------------------------------------------------------
package pcrrip_pkg;

  // default geometry (all sizes are powers of two)
  localparam int unsigned DEF_NUM_SETS      = 2048;
  localparam int unsigned DEF_NUM_WAYS      = 16;
  localparam int unsigned DEF_PC_ENTRIES    = 1024;
  localparam int unsigned DEF_FILTER_BITS   = 2048;
  localparam int unsigned DEF_PRIORITY_BITS = 2;
  localparam int unsigned DEF_COUNTER_MAX   = 1023;

  // fixed field widths
  localparam int unsigned SET_IN_W  = 11;
  localparam int unsigned WAY_IN_W  = 4;
  localparam int unsigned PRIO_O_W  = 2;
  localparam int unsigned BLOCK_W   = 58;
  localparam int unsigned STRIDE_W  = 59;
  localparam int unsigned REPEAT_W  = 8;
  localparam int unsigned THR_W     = 8;
  localparam int unsigned SEED_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // hashing and random source
  localparam logic [31:0]     HASH_MUL  = 32'd2654435761;
  localparam logic [31:0]     HASH_XOR  = 32'h0000dead;
  localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;

  // PC classes
  localparam logic [1:0] CLS_COLD    = 2'd0;
  localparam logic [1:0] CLS_NEUTRAL = 2'd1;
  localparam logic [1:0] CLS_HOT     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATIO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd3;

  // hash operand select
  typedef enum logic [1:0] {
    HS_SIG_A = 2'd0,
    HS_SIG_B = 2'd1,
    HS_PC_A  = 2'd2,
    HS_PC_B  = 2'd3
  } hsel_t;

  typedef struct packed {
    logic  capture;
    logic  age;
    logic  vict_fin;
    logic  cnt;
    logic  cls;
    logic  hash_en;
    hsel_t hsel;
    logic  fwrite;
    logic  fread;
    logic  fin;
  } cmd_t;

  typedef struct packed {
    logic sweep_busy;
    logic vict_found;
    logic out_free;
    logic was_hit;
  } status_t;

endpackage

// ===== hdl/pc_classified_rrip_replacement.sv =====
// ----------------------------------------------------------------------------
// pc_classified_rrip_replacement
// RRIP replacement with PC-based insertion and a Bloom-filter dead predictor.
// ----------------------------------------------------------------------------
// Victim request: the set row is aged one step at a time until a way reaches the maximum priority.
// Updates: a hit skips the hash steps; a miss uses the shared hash multiplier and one filter port.
// One transaction in flight; the next is accepted while a result waits.
// Reset: synchronous, active low; a clearing pass over max(NUM_SETS, PC_ENTRIES,
// FILTER_BITS) entries then runs, during which no transaction is accepted.
module pc_classified_rrip_replacement #(
  parameter int unsigned NUM_SETS      = pcrrip_pkg::DEF_NUM_SETS,
  parameter int unsigned NUM_WAYS      = pcrrip_pkg::DEF_NUM_WAYS,
  parameter int unsigned PC_ENTRIES    = pcrrip_pkg::DEF_PC_ENTRIES,
  parameter int unsigned FILTER_BITS   = pcrrip_pkg::DEF_FILTER_BITS,
  parameter int unsigned PRIORITY_BITS = pcrrip_pkg::DEF_PRIORITY_BITS,
  parameter int unsigned COUNTER_MAX   = pcrrip_pkg::DEF_COUNTER_MAX
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [pcrrip_pkg::SET_IN_W-1:0]  in_set_index,
  input  logic [pcrrip_pkg::WAY_IN_W-1:0]  in_way_index,
  input  logic                             in_was_hit,
  input  logic [63:0]                      in_program_counter,
  input  logic [63:0]                      in_phys_address,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcrrip_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcrrip_pkg::SEED_W-1:0]    cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pcrrip_pkg::WAY_IN_W-1:0]  out_victim_way,
  output logic [pcrrip_pkg::PRIO_O_W-1:0]  out_inserted_priority,
  output logic                             out_stream_detected,
  output logic                             out_demoted,
  output logic [1:0]                       out_pc_class
);
  import pcrrip_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  pcrrip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tables and arithmetic
  pcrrip_dp #(
    .NUM_SETS      (NUM_SETS),
    .NUM_WAYS      (NUM_WAYS),
    .PC_ENTRIES    (PC_ENTRIES),
    .FILTER_BITS   (FILTER_BITS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .COUNTER_MAX   (COUNTER_MAX)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_set_index          (in_set_index),
    .in_way_index          (in_way_index),
    .in_was_hit            (in_was_hit),
    .in_program_counter    (in_program_counter),
    .in_phys_address       (in_phys_address),
    .cfg_valid             (cfg_valid),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_victim_way        (out_victim_way),
    .out_inserted_priority (out_inserted_priority),
    .out_stream_detected   (out_stream_detected),
    .out_demoted           (out_demoted),
    .out_pc_class          (out_pc_class)
  );

endmodule

// ===== hdl/pcrrip_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcrrip_ctrl
// Sequencer for victim searches and access updates.
// ----------------------------------------------------------------------------
module pcrrip_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_stall,
  input  pcrrip_pkg::status_t sts,
  output pcrrip_pkg::cmd_t    cmd
);
  import pcrrip_pkg::*;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_VICT, S_CNT, S_CLS,
    S_H0, S_H1, S_H2, S_H3, S_H4, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // decode commands and next state
  always_comb begin
    cmd       = '0;
    cmd.hsel  = HS_SIG_A;
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP: begin
        if (!sts.sweep_busy) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = in_kind ? S_CNT : S_VICT;
        end
      end
      S_VICT: begin
        if (sts.vict_found) begin
          if (sts.out_free) begin
            cmd.vict_fin = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.age = 1'b1;
        end
      end
      S_CNT: begin
        cmd.cnt   = 1'b1;
        state_nxt = S_CLS;
      end
      S_CLS: begin
        cmd.cls   = 1'b1;
        state_nxt = sts.was_hit ? S_FIN : S_H0;
      end
      S_H0: begin
        cmd.hash_en = 1'b1;
        cmd.hsel    = HS_SIG_A;
        state_nxt   = S_H1;
      end
      S_H1: begin
        cmd.hash_en = 1'b1;
        cmd.hsel    = HS_SIG_B;
        cmd.fwrite  = 1'b1;
        state_nxt   = S_H2;
      end
      S_H2: begin
        cmd.hash_en = 1'b1;
        cmd.hsel    = HS_PC_A;
        cmd.fwrite  = 1'b1;
        state_nxt   = S_H3;
      end
      S_H3: begin
        cmd.hash_en = 1'b1;
        cmd.hsel    = HS_PC_B;
        cmd.fread   = 1'b1;
        state_nxt   = S_H4;
      end
      S_H4: begin
        cmd.fread = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/pcrrip_dp.sv =====
// ----------------------------------------------------------------------------
// pcrrip_dp
// Set and PC table memories, dead-block filter, hash multiplier, LFSR,
// configuration registers and result register.
// ----------------------------------------------------------------------------
module pcrrip_dp #(
  parameter int unsigned NUM_SETS      = pcrrip_pkg::DEF_NUM_SETS,
  parameter int unsigned NUM_WAYS      = pcrrip_pkg::DEF_NUM_WAYS,
  parameter int unsigned PC_ENTRIES    = pcrrip_pkg::DEF_PC_ENTRIES,
  parameter int unsigned FILTER_BITS   = pcrrip_pkg::DEF_FILTER_BITS,
  parameter int unsigned PRIORITY_BITS = pcrrip_pkg::DEF_PRIORITY_BITS,
  parameter int unsigned COUNTER_MAX   = pcrrip_pkg::DEF_COUNTER_MAX
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pcrrip_pkg::cmd_t                     cmd,
  output pcrrip_pkg::status_t                  sts,
  input  logic [pcrrip_pkg::SET_IN_W-1:0]      in_set_index,
  input  logic [pcrrip_pkg::WAY_IN_W-1:0]      in_way_index,
  input  logic                                 in_was_hit,
  input  logic [63:0]                          in_program_counter,
  input  logic [63:0]                          in_phys_address,
  input  logic                                 cfg_valid,
  input  logic [pcrrip_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcrrip_pkg::SEED_W-1:0]        cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pcrrip_pkg::WAY_IN_W-1:0]      out_victim_way,
  output logic [pcrrip_pkg::PRIO_O_W-1:0]      out_inserted_priority,
  output logic                                 out_stream_detected,
  output logic                                 out_demoted,
  output logic [1:0]                           out_pc_class
);
  import pcrrip_pkg::*;

  localparam int unsigned SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WAY_W  = $clog2(NUM_WAYS);
  localparam int unsigned PCI_W  = $clog2(PC_ENTRIES);
  localparam int unsigned FB_W   = $clog2(FILTER_BITS);
  localparam int unsigned CNT_W  = $clog2(COUNTER_MAX + 1);
  localparam int unsigned PB     = PRIORITY_BITS;
  localparam int unsigned PRIO_MAX_I = (1 << PB) - 1;
  localparam logic [PB-1:0] PRIO_MAX  = PB'(PRIO_MAX_I);
  localparam logic [PB-1:0] PRIO_INIT = PB'(PRIO_MAX_I - 1);
  localparam int unsigned SWP_A  = (NUM_SETS > PC_ENTRIES) ? NUM_SETS : PC_ENTRIES;
  localparam int unsigned SWP_N  = (SWP_A > FILTER_BITS) ? SWP_A : FILTER_BITS;
  localparam int unsigned SWP_W  = $clog2(SWP_N + 1);

  typedef logic [NUM_WAYS-1:0][PB-1:0]    prow_t;
  typedef logic [NUM_WAYS-1:0]            hrow_t;
  typedef logic [NUM_WAYS-1:0][PCI_W-1:0] srow_t;

  // memories
  prow_t              prio_mem [NUM_SETS];
  hrow_t              hit_mem  [NUM_SETS];
  srow_t              sig_mem  [NUM_SETS];
  logic [CNT_W-1:0]   hcnt_mem [PC_ENTRIES];
  logic [CNT_W-1:0]   mcnt_mem [PC_ENTRIES];
  logic               lbv_mem  [PC_ENTRIES];
  logic [BLOCK_W-1:0] lblk_mem [PC_ENTRIES];
  logic [STRIDE_W-1:0] lstr_mem[PC_ENTRIES];
  logic [REPEAT_W-1:0] rep_mem [PC_ENTRIES];
  logic               filt_mem [FILTER_BITS];

  // control registers
  logic [SWP_W-1:0]   sweep_r;
  logic [THR_W-1:0]   ratio_r, sthr_r, mask_r;
  logic [SEED_W-1:0]  lfsr_r;
  logic               out_valid_r;

  // payload registers
  logic               was_hit_r;
  logic [SET_W-1:0]   set_r;
  logic [WAY_W-1:0]   way_r;
  logic [PCI_W-1:0]   pci_r;
  logic [BLOCK_W-1:0] blk_r;
  prow_t              prio_row_r;
  hrow_t              hit_row_r;
  srow_t              sig_row_r;
  logic [CNT_W-1:0]   hcnt_rd_r, mcnt_rd_r, hcnt_n_r, mcnt_n_r;
  logic               lbv_rd_r;
  logic [BLOCK_W-1:0] lblk_rd_r;
  logic [STRIDE_W-1:0] lstr_rd_r, lstr_n_r;
  logic [REPEAT_W-1:0] rep_rd_r, rep_n_r;
  logic               dead_add_r;
  logic [1:0]         cls_r;
  logic [31:0]        hprod_r;
  logic               f_rd_r, fa_r;
  logic [WAY_IN_W-1:0] o_victim_r;
  logic [PRIO_O_W-1:0] o_prio_r;
  logic               o_stream_r, o_demoted_r;
  logic [1:0]         o_cls_r;

  logic               sweep_busy;
  logic [SET_W-1:0]   set_in;
  logic [WAY_W-1:0]   way_in;
  logic [PCI_W-1:0]   pci_in;
  logic [15:0]        set_ext;
  logic [4:0]         way_ext;
  prow_t              prio_init_row;
  logic               found;
  logic [WAY_W-1:0]   first_way;
  logic               out_free;

  assign sweep_busy = (sweep_r < SWP_W'(SWP_N));
  assign set_ext    = 16'(in_set_index);
  assign way_ext    = 5'(in_way_index);
  assign set_in     = set_ext[SET_W-1:0];
  assign way_in     = way_ext[WAY_W-1:0];
  assign pci_in     = in_program_counter[PCI_W+1:2];
  assign out_free   = !out_valid_r || !out_stall;

  // find the first way at the maximum priority
  always_comb begin
    found     = 1'b0;
    first_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (prio_row_r[w] == PRIO_MAX) begin
        found     = 1'b1;
        first_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) prio_init_row[w] = PRIO_INIT;
  end

  assign sts.sweep_busy = sweep_busy;
  assign sts.vict_found = found;
  assign sts.out_free   = out_free;
  assign sts.was_hit    = was_hit_r;

  // stride and counter update terms
  logic [STRIDE_W-1:0] prev_blk, diff;
  logic                stride_match;
  logic [CNT_W-1:0]    hcnt_inc, mcnt_inc;
  logic [REPEAT_W-1:0] rep_inc;

  always_comb begin
    prev_blk     = lbv_rd_r ? STRIDE_W'(lblk_rd_r) : '1;
    diff         = STRIDE_W'(blk_r) - prev_blk;
    stride_match = lbv_rd_r && (diff == lstr_rd_r);
    hcnt_inc     = (hcnt_rd_r < CNT_W'(COUNTER_MAX)) ? hcnt_rd_r + 1'b1 : hcnt_rd_r;
    mcnt_inc     = (mcnt_rd_r < CNT_W'(COUNTER_MAX)) ? mcnt_rd_r + 1'b1 : mcnt_rd_r;
    rep_inc      = (rep_rd_r != '1) ? rep_rd_r + 1'b1 : rep_rd_r;
  end

  // classification products
  logic [CNT_W+THR_W-1:0] rm, rh, h_ext, m_ext;
  logic [1:0]             cls_nxt;

  always_comb begin
    rm    = (CNT_W+THR_W)'(ratio_r) * (CNT_W+THR_W)'(mcnt_n_r);
    rh    = (CNT_W+THR_W)'(ratio_r) * (CNT_W+THR_W)'(hcnt_n_r);
    h_ext = (CNT_W+THR_W)'(hcnt_n_r);
    m_ext = (CNT_W+THR_W)'(mcnt_n_r);
    priority if (h_ext > rm) cls_nxt = CLS_HOT;
    else if (m_ext > rh)     cls_nxt = CLS_COLD;
    else                     cls_nxt = CLS_NEUTRAL;
  end

  // hash operand
  logic [31:0] hin;
  always_comb begin
    unique case (cmd.hsel)
      HS_SIG_A: hin = 32'(sig_row_r[way_r]);
      HS_SIG_B: hin = 32'(sig_row_r[way_r]) ^ HASH_XOR;
      HS_PC_A:  hin = 32'(pci_r);
      HS_PC_B:  hin = 32'(pci_r) ^ HASH_XOR;
      default:  hin = 32'(pci_r);
    endcase
  end

  // insertion decision
  logic                stream;
  logic [SEED_W-1:0]   lfsr_step;
  logic [PB-1:0]       ins_prio;
  logic                demote;

  always_comb begin
    stream    = (rep_n_r >= sthr_r);
    lfsr_step = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : '0);
    demote    = 1'b0;
    priority if (stream) begin
      ins_prio = ((lfsr_step[THR_W-1:0] & mask_r) == '0) ? '0 : PRIO_MAX;
    end else if (cls_r == CLS_HOT) begin
      ins_prio = '0;
    end else if (cls_r == CLS_COLD || (fa_r && f_rd_r)) begin
      ins_prio = PRIO_MAX;
      demote   = 1'b1;
    end else begin
      ins_prio = PRIO_INIT;
    end
  end

  // control state: sweep, configuration, lfsr, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      ratio_r     <= 8'd8;
      sthr_r      <= 8'd2;
      mask_r      <= 8'd31;
      lfsr_r      <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (sweep_busy) sweep_r <= sweep_r + 1'b1;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_RATIO:  ratio_r <= cfg_data[THR_W-1:0];
          REG_STREAM: sthr_r  <= cfg_data[THR_W-1:0];
          REG_MASK:   mask_r  <= cfg_data[THR_W-1:0];
          REG_SEED:   lfsr_r  <= (cfg_data == '0) ? 16'd1 : cfg_data;
          default:    ;
        endcase
      end
      if (cmd.fin && !was_hit_r && stream) lfsr_r <= lfsr_step;
      if (cmd.vict_fin || cmd.fin) out_valid_r <= 1'b1;
      else if (!out_stall)         out_valid_r <= 1'b0;
    end
  end

  // capture the transaction and read its set and PC rows, or age the captured set row
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      was_hit_r  <= in_was_hit;
      set_r      <= set_in;
      way_r      <= way_in;
      pci_r      <= pci_in;
      blk_r      <= in_phys_address[63:6];
      prio_row_r <= prio_mem[set_in];
      hit_row_r  <= hit_mem[set_in];
      sig_row_r  <= sig_mem[set_in];
      hcnt_rd_r  <= hcnt_mem[pci_in];
      mcnt_rd_r  <= mcnt_mem[pci_in];
      lbv_rd_r   <= lbv_mem[pci_in];
      lblk_rd_r  <= lblk_mem[pci_in];
      lstr_rd_r  <= lstr_mem[pci_in];
      rep_rd_r   <= rep_mem[pci_in];
    end else if (cmd.age) begin
      for (int w = 0; w < NUM_WAYS; w++) prio_row_r[w] <= prio_row_r[w] + 1'b1;
    end
    // advance counters and stride tracking, then class, hash product and filter reads
    if (cmd.cnt) begin
      dead_add_r <= !hit_row_r[way_r];
      if (was_hit_r) begin
        hcnt_n_r <= hcnt_inc;
        mcnt_n_r <= mcnt_rd_r;
        lstr_n_r <= lstr_rd_r;
        rep_n_r  <= rep_rd_r;
      end else begin
        hcnt_n_r <= hcnt_rd_r;
        mcnt_n_r <= mcnt_inc;
        lstr_n_r <= stride_match ? lstr_rd_r : diff;
        rep_n_r  <= stride_match ? rep_inc : REPEAT_W'(1);
      end
    end
    if (cmd.cls)     cls_r   <= cls_nxt;
    if (cmd.hash_en) hprod_r <= hin * HASH_MUL;
    if (cmd.fread) begin
      fa_r   <= f_rd_r;
      f_rd_r <= filt_mem[hprod_r[FB_W-1:0]];
    end
  end

  // set memories: clearing pass, victim aging write-back, line update
  always_ff @(posedge clk) begin
    if (sweep_busy) begin
      if (sweep_r < SWP_W'(NUM_SETS)) begin
        prio_mem[sweep_r[SET_W-1:0]] <= prio_init_row;
        hit_mem[sweep_r[SET_W-1:0]]  <= '0;
        sig_mem[sweep_r[SET_W-1:0]]  <= '0;
      end
    end else if (cmd.vict_fin) begin
      prio_mem[set_r] <= prio_row_r;
    end else if (cmd.fin) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (WAY_W'(w) == way_r) begin
          prio_mem[set_r][w] <= was_hit_r ? '0 : ins_prio;
          hit_mem[set_r][w]  <= was_hit_r;
          sig_mem[set_r][w]  <= was_hit_r ? sig_row_r[w] : pci_r;
        end else begin
          prio_mem[set_r][w] <= prio_row_r[w];
          hit_mem[set_r][w]  <= hit_row_r[w];
          sig_mem[set_r][w]  <= sig_row_r[w];
        end
      end
    end
  end

  // PC memories
  always_ff @(posedge clk) begin
    if (sweep_busy) begin
      if (sweep_r < SWP_W'(PC_ENTRIES)) begin
        hcnt_mem[sweep_r[PCI_W-1:0]] <= '0;
        mcnt_mem[sweep_r[PCI_W-1:0]] <= '0;
        lbv_mem[sweep_r[PCI_W-1:0]]  <= 1'b0;
        lblk_mem[sweep_r[PCI_W-1:0]] <= '0;
        lstr_mem[sweep_r[PCI_W-1:0]] <= '0;
        rep_mem[sweep_r[PCI_W-1:0]]  <= '0;
      end
    end else if (cmd.fin) begin
      hcnt_mem[pci_r] <= hcnt_n_r;
      mcnt_mem[pci_r] <= mcnt_n_r;
      lbv_mem[pci_r]  <= was_hit_r ? lbv_rd_r : 1'b1;
      lblk_mem[pci_r] <= was_hit_r ? lblk_rd_r : blk_r;
      lstr_mem[pci_r] <= lstr_n_r;
      rep_mem[pci_r]  <= rep_n_r;
    end
  end

  // dead-block filter
  always_ff @(posedge clk) begin
    if (sweep_busy) begin
      if (sweep_r < SWP_W'(FILTER_BITS)) filt_mem[sweep_r[FB_W-1:0]] <= 1'b0;
    end else if (cmd.fwrite && dead_add_r) begin
      filt_mem[hprod_r[FB_W-1:0]] <= 1'b1;
    end
  end

  // load the result register
  always_ff @(posedge clk) begin
    if (cmd.vict_fin) begin
      o_victim_r  <= WAY_IN_W'(5'(first_way));
      o_prio_r    <= '0;
      o_stream_r  <= 1'b0;
      o_demoted_r <= 1'b0;
      o_cls_r     <= CLS_COLD;
    end else if (cmd.fin) begin
      o_victim_r  <= '0;
      o_prio_r    <= was_hit_r ? '0 : PRIO_O_W'(4'(ins_prio));
      o_stream_r  <= !was_hit_r && stream;
      o_demoted_r <= !was_hit_r && !stream && demote;
      o_cls_r     <= cls_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_victim_way        = o_victim_r;
  assign out_inserted_priority = o_prio_r;
  assign out_stream_detected   = o_stream_r;
  assign out_demoted           = o_demoted_r;
  assign out_pc_class          = o_cls_r;

endmodule
